>>> rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared types and constants of the software timer set unit
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int NumTimers = 32;
  localparam int IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW      = $clog2(NumTimers + 1);

  localparam int InDataW   = 104;
  localparam int OutDataW  = 40;

  localparam logic [30:0] RemMax  = 31'h7fff_ffff;
  localparam logic [9:0]  NsPerUs = 10'd1000;

  // ceil(2^45 / 125), exact quotient for 38-bit dividends
  localparam logic [38:0] RecipM   = 39'd281474976711;
  // first nanosecond difference whose microsecond count exceeds RemMax
  localparam logic [40:0] DivSatNs = 41'd2147483648000;

  typedef enum logic [2:0] {
    K_SCHEDULE = 3'd0,
    K_START    = 3'd1,
    K_STOP     = 3'd2,
    K_SET_PER  = 3'd3,
    K_CLR_PER  = 3'd4,
    K_QUERY    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RUNNING = 2'd1,
    ST_NONE    = 2'd2
  } status_e;

  localparam logic RK_EXPIRY = 1'b0;
  localparam logic RK_DONE   = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_ADD  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_RINT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

endpackage

>>> rtl/software_timer_set_unit.sv
// ----------------------------------------------------------------------------
// software_timer_set_unit
// timer set with deadline-ordered expiry, periodic re-arm and remaining time
// ----------------------------------------------------------------------------
// channel  dir  tdata                                     tuser        tlast
// s_axis   in   timer_index, interval_us, now_ns          kind         -
// m_axis   out  timer_id, remaining_us, status            result_kind  last
//
// deadlines and intervals live in single-port-read memories, one read a cycle
// control items pass S_RD and S_OUT (start adds S_ADD), queries add a two-step reciprocal multiply
// schedule takes one full memory scan per expiry, plus
// a scan that finds nothing due, a nearest-deadline scan and the multiply;
// re-arm adds the S_RINT and S_ADD states per periodic timer
// reset clears flags and deadline valid bits at once, no clearing pass
// input waits while a result is held in the output register
// ----------------------------------------------------------------------------
module software_timer_set_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // timer_index[4:0], interval_us[36:5], now_ns[100:37], zeros
  input  logic [sts_pkg::InDataW-1:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // timer_id[4:0], remaining_us[35:5], status[37:36], zeros
  output logic [sts_pkg::OutDataW-1:0] m_axis_tdata,
  // result_kind[0]
  output logic [0:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);
  import sts_pkg::*;

  state_e state_q, state_d;

  logic [63:0]          dl_mem  [NumTimers];
  logic [31:0]          ivl_mem [NumTimers];
  logic [63:0]          dl_rd_q;
  logic [31:0]          ivl_rd_q;
  logic [IdxW-1:0]      raddr, rd_idx_q;
  logic [NumTimers-1:0] dl_val_q, dl_val_d;
  logic [NumTimers-1:0] run_q, run_d, per_q, per_d, done_q, done_d;

  logic [2:0]      kind_q, kind_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     ivl_q, ivl_d;
  logic [63:0]     now_q, now_d;

  logic [41:0]     prod_q, prod_d;
  logic [63:0]     base_q, base_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic            rearm_q, rearm_d;
  logic            dl_we, ivl_we;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d, have_q, have_d, near_q, near_d;
  logic [63:0]     best_q, best_d;
  logic [IdxW-1:0] bidx_q, bidx_d;

  logic [63:0] div_n_q, div_n_d;
  logic [76:0] div_acc_q, div_acc_d;
  logic        div_cnt_q, div_cnt_d;

  logic        ovld_q, ovld_d, rk_q, rk_d, last_q, last_d;
  logic [4:0]  id_q, id_d;
  logic [30:0] rem_q, rem_d;
  logic [1:0]  st_q, st_d;

  logic [63:0] dl_eff, sum;
  logic [64:0] sum_w;
  logic        cand;
  logic [18:0] div_a;
  logic [57:0] div_pp;
  logic [76:0] div_sum;
  logic        div_sat;
  logic [4:0]  in_idx;

  assign in_idx = s_axis_tdata[4:0];
  assign dl_eff = dl_val_q[rd_idx_q] ? dl_rd_q : 64'd0;
  assign sum_w  = {1'b0, base_q} + {23'd0, prod_q};
  assign sum    = sum_w[64] ? {64{1'b1}} : sum_w[63:0];
  assign cand   = near_q ? run_q[rd_idx_q]
                         : (run_q[rd_idx_q] && !done_q[rd_idx_q] && dl_eff <= now_q);

  // ns / 1000 as (ns >> 3) / 125, reciprocal product in two 19-bit halves
  assign div_a   = div_cnt_q ? div_n_q[40:22] : div_n_q[21:3];
  assign div_pp  = 58'(div_a) * 58'(RecipM);
  assign div_sum = div_acc_q + {div_pp, 19'd0};
  assign div_sat = (|div_n_q[63:41]) || (div_n_q[40:0] >= DivSatNs);

  always_comb begin
    if (state_q == S_SCAN && cnt_q < CntW'(NumTimers)) begin
      raddr = cnt_q[IdxW-1:0];
    end else if (state_q == S_SCAN) begin
      raddr = bidx_q;
    end else if (state_q == S_IDLE) begin
      raddr = IdxW'(in_idx);
    end else begin
      raddr = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[wr_idx_q] <= sum;
    end
    if (ivl_we) begin
      ivl_mem[idx_q] <= ivl_q;
    end
    dl_rd_q  <= dl_mem[raddr];
    ivl_rd_q <= ivl_mem[raddr];
    rd_idx_q <= raddr;
  end

  always_comb begin
    state_d   = state_q;
    dl_val_d  = dl_val_q;
    run_d     = run_q;
    per_d     = per_q;
    done_d    = done_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    ivl_d     = ivl_q;
    now_d     = now_q;
    prod_d    = prod_q;
    base_d    = base_q;
    wr_idx_d  = wr_idx_q;
    rearm_d   = rearm_q;
    dl_we     = 1'b0;
    ivl_we    = 1'b0;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    have_d    = have_q;
    near_d    = near_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    div_n_d   = div_n_q;
    div_acc_d = div_acc_q;
    div_cnt_d = div_cnt_q;
    ovld_d    = ovld_q;
    rk_d      = rk_q;
    id_d      = id_q;
    rem_d     = rem_q;
    st_d      = st_q;
    last_d    = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d = s_axis_tuser;
          idx_d  = IdxW'(in_idx);
          ivl_d  = s_axis_tdata[36:5];
          now_d  = s_axis_tdata[100:37];
          rk_d   = RK_DONE;
          id_d   = 5'd0;
          rem_d  = 31'd0;
          st_d   = ST_OK;
          last_d = 1'b1;
          if (s_axis_tuser == K_SCHEDULE) begin
            done_d  = '0;
            near_d  = 1'b0;
            cnt_d   = '0;
            pend_d  = 1'b0;
            have_d  = 1'b0;
            state_d = S_SCAN;
          end else if (s_axis_tuser > K_QUERY || {2'b0, in_idx} >= 7'(NumTimers)) begin
            ovld_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_OUT;
        ovld_d  = 1'b1;
        unique case (kind_q)
          K_START: begin
            if (run_q[idx_q]) begin
              st_d = ST_RUNNING;
            end else begin
              prod_d   = 42'(ivl_q) * 42'(NsPerUs);
              base_d   = (per_q[idx_q] && dl_eff != 64'd0) ? dl_eff : now_q;
              wr_idx_d = idx_q;
              rearm_d  = 1'b0;
              ivl_we   = 1'b1;
              ovld_d   = 1'b0;
              state_d  = S_ADD;
            end
          end
          K_STOP: begin
            run_d[idx_q] = 1'b0;
            per_d[idx_q] = 1'b0;
          end
          K_SET_PER: per_d[idx_q] = 1'b1;
          K_CLR_PER: per_d[idx_q] = 1'b0;
          default: begin
            if (run_q[idx_q] && now_q < dl_eff) begin
              div_n_d   = dl_eff - now_q;
              div_cnt_d = 1'b0;
              ovld_d    = 1'b0;
              state_d   = S_DIV;
            end
          end
        endcase
      end
      S_ADD: begin
        dl_we              = 1'b1;
        dl_val_d[wr_idx_q] = 1'b1;
        run_d[wr_idx_q]    = 1'b1;
        ovld_d             = 1'b1;
        state_d            = S_OUT;
      end
      S_SCAN: begin
        if (cnt_q < CntW'(NumTimers)) begin
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (cand && (!have_q || dl_eff < best_q)) begin
            have_d = 1'b1;
            best_d = dl_eff;
            bidx_d = rd_idx_q;
          end
        end else if (cnt_q == CntW'(NumTimers)) begin
          if (!near_q) begin
            if (have_q) begin
              run_d[bidx_q]  = 1'b0;
              done_d[bidx_q] = 1'b1;
              rk_d   = RK_EXPIRY;
              id_d   = 5'(bidx_q);
              rem_d  = 31'd0;
              st_d   = ST_OK;
              last_d = 1'b0;
              if (per_q[bidx_q]) begin
                state_d = S_RINT;
              end else begin
                ovld_d  = 1'b1;
                state_d = S_OUT;
              end
            end else begin
              near_d = 1'b1;
              cnt_d  = '0;
              have_d = 1'b0;
            end
          end else begin
            rk_d   = RK_DONE;
            id_d   = 5'd0;
            rem_d  = 31'd0;
            last_d = 1'b1;
            if (!have_q) begin
              st_d    = ST_NONE;
              ovld_d  = 1'b1;
              state_d = S_OUT;
            end else if (now_q < best_q) begin
              st_d      = ST_OK;
              div_n_d   = best_q - now_q;
              div_cnt_d = 1'b0;
              state_d   = S_DIV;
            end else begin
              st_d    = ST_OK;
              ovld_d  = 1'b1;
              state_d = S_OUT;
            end
          end
        end
      end
      S_RINT: begin
        prod_d   = 42'(ivl_rd_q) * 42'(NsPerUs);
        base_d   = best_q;
        wr_idx_d = bidx_q;
        rearm_d  = 1'b1;
        state_d  = S_ADD;
      end
      S_DIV: begin
        div_cnt_d = 1'b1;
        if (!div_cnt_q) begin
          div_acc_d = 77'(div_pp);
        end else begin
          rem_d   = div_sat ? RemMax : div_sum[75:45];
          ovld_d  = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          ovld_d = 1'b0;
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            near_d  = 1'b0;
            cnt_d   = '0;
            pend_d  = 1'b0;
            have_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      dl_val_q <= '0;
      run_q    <= '0;
      per_q    <= '0;
      done_q   <= '0;
      ovld_q   <= 1'b0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      have_q   <= 1'b0;
      near_q   <= 1'b0;
      div_cnt_q <= 1'b0;
      rearm_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      dl_val_q <= dl_val_d;
      run_q    <= run_d;
      per_q    <= per_d;
      done_q   <= done_d;
      ovld_q   <= ovld_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      have_q   <= have_d;
      near_q   <= near_d;
      div_cnt_q <= div_cnt_d;
      rearm_q  <= rearm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    idx_q     <= idx_d;
    ivl_q     <= ivl_d;
    now_q     <= now_d;
    prod_q    <= prod_d;
    base_q    <= base_d;
    wr_idx_q  <= wr_idx_d;
    best_q    <= best_d;
    bidx_q    <= bidx_d;
    div_n_q   <= div_n_d;
    div_acc_q <= div_acc_d;
    rk_q      <= rk_d;
    id_q      <= id_d;
    rem_q     <= rem_d;
    st_q      <= st_d;
    last_q    <= last_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {2'b00, st_q, rem_q, id_q};
  assign m_axis_tuser  = rk_q;
  assign m_axis_tlast  = last_q;

  // input and output never both open
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input open while result pending");

  // a non-final result is always an expiry
  a_exp_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == RK_EXPIRY))
    else $error("non-final completion result");

  // re-arm always leaves the timer running
  a_rearm_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD && rearm_q) |=> run_q[$past(wr_idx_q)])
    else $error("re-armed timer not running");

endmodule
